// ----- src/sorted_key_group_averager_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key group averager
// Shared concurrent assertion forms, clocked on the rising edge and muted
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_GROUP_AVERAGER_MACROS_SVH
`define SORTED_KEY_GROUP_AVERAGER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKGA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SKGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- src/skga_pkg.sv -----
// ----------------------------------------------------------------------------
// skga_pkg
// Types, widths and defaults shared by the sorted key group averager.
// ----------------------------------------------------------------------------
package skga_pkg;

  // Field widths of the row and result items.
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  // Row counter covers the largest allowed run length.
  localparam int ROW_CNT_W = 16;
  // Sum of up to 65535 values of 32 bits.
  localparam int SUM_W     = VAL_W + ROW_CNT_W;

  // Defaults for the top-level parameters.
  localparam int MAX_RUN_DEFAULT           = 65535;
  localparam int MAX_VALUE_COLUMNS_DEFAULT = 2;

  // Reset value of the column count register.
  localparam logic [1:0] COLS_RESET = 2'd1;

  // Group record queue between front and back; depth is a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Quotient bits the divider resolves per clock.
  localparam int DIV_BITS_PER_CYCLE = 2;

  // One input item: a row of the table.
  typedef struct packed {
    logic signed [KEY_W-1:0] row_key;
    logic signed [VAL_W-1:0] row_value_a;
    logic signed [VAL_W-1:0] row_value_b;
    logic                    row_is_final;
  } row_item_t;

  // One result item: a closed group.
  typedef struct packed {
    logic signed [KEY_W-1:0] group_key;
    logic signed [VAL_W-1:0] group_avg_a;
    logic signed [VAL_W-1:0] group_avg_b;
    logic                    group_is_final;
  } group_item_t;

  // A closed group waiting for its averages.
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [ROW_CNT_W-1:0]    rows;
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic                    is_final;
  } group_rec_t;

  // Records pushed by the front in one cycle: none, one or two.
  typedef struct packed {
    logic [1:0] count;
    group_rec_t first;
    group_rec_t second;
  } queue_push_t;

  // Divider request and response.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [ROW_CNT_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV_A,
    B_DIV_B,
    B_OUT
  } back_state_t;

endpackage

// ----- src/sorted_key_group_averager.sv -----
// ----------------------------------------------------------------------------
// sorted_key_group_averager
// Group-by-key averaging of a key-sorted table of signed Q16.16 rows.
// ----------------------------------------------------------------------------
// A row is taken whenever the group queue has room for two records, so
// rows stream at one per cycle until three closed groups wait in the queue.
// Each closed group is then loaded by the back end, divided once per value
// column in the shared divider (two quotient bits a cycle over the 48-bit
// sum) and held in the output register until it is taken. The divider sets
// the sustained group rate; rows that stay in an open group push no record.
// The column count register is to be written only while the block is idle;
// the user must see to this, as the block has no guard for it.
module sorted_key_group_averager
  import skga_pkg::*;
#(
  parameter int MAX_RUN           = MAX_RUN_DEFAULT,
  parameter int MAX_VALUE_COLUMNS = MAX_VALUE_COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        row_valid,
  output logic        row_ready,
  input  row_item_t   row,
  output logic        result_valid,
  input  logic        result_ready,
  output group_item_t result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);

  logic        [1:0] value_columns;
  logic        [1:0] cols_sat;
  logic        [1:0] cols;
  queue_push_t       push;
  group_rec_t        head;
  logic              empty;
  logic              room;
  logic              pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Column count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_columns <= COLS_RESET;
    end else if (cfg_we) begin
      value_columns <= cfg_data;
    end
  end

  // Three columns act as two, then limited by the build.
  always_comb begin
    cols_sat = (value_columns == 2'd3) ? 2'd2 : value_columns;
    cols     = (cols_sat > 2'(MAX_VALUE_COLUMNS)) ? 2'(MAX_VALUE_COLUMNS) : cols_sat;
  end

  skga_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row),
    .room      (room),
    .push      (push)
  );

  skga_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .room  (room)
  );

  skga_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  skga_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cols         (cols),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- src/skga_front.sv -----
// ----------------------------------------------------------------------------
// skga_front
// Accepts rows, keeps the open group and pushes closed groups to the queue.
// ----------------------------------------------------------------------------
module skga_front
  import skga_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        row_valid,
  output logic        row_ready,
  input  row_item_t   row,
  input  logic        room,
  output queue_push_t push
);

  // Open group state.
  logic                    open;
  logic [KEY_W-1:0]        held_key;
  logic [ROW_CNT_W-1:0]    rows;
  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;

  logic                    accept;
  logic                    close;
  logic                    start_new;
  logic signed [SUM_W-1:0] val_a;
  logic signed [SUM_W-1:0] val_b;
  logic [ROW_CNT_W-1:0]    rows_next;
  logic signed [SUM_W-1:0] sum_a_next;
  logic signed [SUM_W-1:0] sum_b_next;
  group_rec_t              old_rec;
  group_rec_t              new_rec;

  // An item is taken only when the queue can hold two records.
  assign row_ready = room;
  assign accept    = row_valid && row_ready;

  // Classify the row against the open group.
  always_comb begin
    val_a     = {{(SUM_W-VAL_W){row.row_value_a[VAL_W-1]}}, row.row_value_a};
    val_b     = {{(SUM_W-VAL_W){row.row_value_b[VAL_W-1]}}, row.row_value_b};
    close     = open && ((row.row_key != held_key) || (rows >= ROW_CNT_W'(MAX_RUN)));
    start_new = !open || close;
    if (start_new) begin
      rows_next  = ROW_CNT_W'(1);
      sum_a_next = val_a;
      sum_b_next = val_b;
    end else begin
      rows_next  = rows + ROW_CNT_W'(1);
      sum_a_next = sum_a + val_a;
      sum_b_next = sum_b + val_b;
    end
  end

  // Records for the group closed by this row and for the flushed group.
  always_comb begin
    old_rec.key      = held_key;
    old_rec.rows     = rows;
    old_rec.sum_a    = sum_a;
    old_rec.sum_b    = sum_b;
    old_rec.is_final = 1'b0;
    new_rec.key      = row.row_key;
    new_rec.rows     = rows_next;
    new_rec.sum_a    = sum_a_next;
    new_rec.sum_b    = sum_b_next;
    new_rec.is_final = 1'b1;
    push.count       = accept ? ({1'b0, close} + {1'b0, row.row_is_final}) : 2'd0;
    push.first       = close ? old_rec : new_rec;
    push.second      = new_rec;
  end

  // Update the open group; the final row clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      open     <= 1'b0;
      held_key <= '0;
      rows     <= '0;
      sum_a    <= '0;
      sum_b    <= '0;
    end else if (accept) begin
      if (row.row_is_final) begin
        open     <= 1'b0;
        held_key <= '0;
        rows     <= '0;
        sum_a    <= '0;
        sum_b    <= '0;
      end else begin
        open     <= 1'b1;
        held_key <= row.row_key;
        rows     <= rows_next;
        sum_a    <= sum_a_next;
        sum_b    <= sum_b_next;
      end
    end
  end

endmodule

// ----- src/skga_queue.sv -----
// ----------------------------------------------------------------------------
// skga_queue
// Short queue of closed group records; takes up to two records a cycle.
// ----------------------------------------------------------------------------
`include "sorted_key_group_averager_macros.svh"

module skga_queue
  import skga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_push_t push,
  input  logic        pop,
  output group_rec_t  head,
  output logic        empty,
  output logic        room
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  group_rec_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;
  logic [PTR_W-1:0] wptr_p1;

  assign wptr_p1 = wptr + PTR_W'(1);
  assign head    = entries[rptr];
  assign empty   = (count == '0);
  assign room    = (count <= (PTR_W+1)'(QUEUE_DEPTH - 2));

  // Record storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wptr_p1] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end
  end

  // The back never pops an empty queue, and the front pushes only with room.
  `SKGA_ASSERT_IMP(a_pop_not_empty, clk, rst, pop, !empty)
  `SKGA_ASSERT_IMP(a_push_has_room, clk, rst, push.count != 2'd0, room)
  `SKGA_ASSERT_IMP(a_count_in_range, clk, rst, 1'b1, count <= (PTR_W+1)'(QUEUE_DEPTH))

endmodule

// ----- src/skga_div.sv -----
// ----------------------------------------------------------------------------
// skga_div
// Shared signed-by-unsigned divider, restoring, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module skga_div
  import skga_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS = (SUM_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
  localparam int CNT_W = $clog2(STEPS);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [SUM_W-1:0]     quo;
  logic [ROW_CNT_W-1:0] rem;
  logic [ROW_CNT_W-1:0] divisor;
  logic                 neg;

  logic [SUM_W-1:0]     quo_w;
  logic [ROW_CNT_W-1:0] rem_w;
  logic [ROW_CNT_W:0]   trial;
  logic [SUM_W-1:0]     mag;
  logic [SUM_W-1:0]     quo_neg;

  // Magnitude of the dividend; the sign is restored at the end.
  assign mag = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;

  // Combinational shift-subtract steps of one iteration.
  always_comb begin
    quo_w = quo;
    rem_w = rem;
    for (int j = 0; j < DIV_BITS_PER_CYCLE; j++) begin
      trial = {rem_w, quo_w[SUM_W-1]};
      quo_w = {quo_w[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_w    = ROW_CNT_W'(trial - {1'b0, divisor});
        quo_w[0] = 1'b1;
      end else begin
        rem_w = trial[ROW_CNT_W-1:0];
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= mag;
      rem     <= '0;
      divisor <= req.divisor;
      neg     <= req.dividend[SUM_W-1];
    end else if (busy) begin
      quo <= quo_w;
      rem <= rem_w;
    end
  end

  // Truncation toward zero: negate the magnitude quotient for a negative sum.
  assign quo_neg      = ~quo + SUM_W'(1);
  assign rsp.done     = done;
  assign rsp.quotient = neg ? quo_neg[VAL_W-1:0] : quo[VAL_W-1:0];

endmodule

// ----- src/skga_back.sv -----
// ----------------------------------------------------------------------------
// skga_back
// Takes closed group records, runs the divider per column and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
`include "sorted_key_group_averager_macros.svh"

module skga_back
  import skga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  cols,
  input  group_rec_t  head,
  input  logic        empty,
  output logic        pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        result_valid,
  input  logic        result_ready,
  output group_item_t result
);

  back_state_t state;
  back_state_t state_next;
  group_rec_t  rec;
  group_item_t res;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = (cols == 2'd0) ? B_OUT : B_DIV_A;
        end
      end
      B_DIV_A: begin
        if (div_rsp.done) begin
          state_next = (cols >= 2'd2) ? B_DIV_B : B_OUT;
        end
      end
      B_DIV_B: begin
        if (div_rsp.done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (result_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop              = (state == B_IDLE) && !empty;
    div_req.start    = (pop && (cols != 2'd0)) ||
                       ((state == B_DIV_A) && div_rsp.done && (cols >= 2'd2));
    div_req.dividend = (state == B_IDLE) ? head.sum_a : rec.sum_b;
    div_req.divisor  = (state == B_IDLE) ? head.rows : rec.rows;
    result_valid     = (state == B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working record and result register; unused averages stay zero.
  always_ff @(posedge clk) begin
    if (pop) begin
      rec                <= head;
      res.group_key      <= head.key;
      res.group_avg_a    <= '0;
      res.group_avg_b    <= '0;
      res.group_is_final <= head.is_final;
    end else if ((state == B_DIV_A) && div_rsp.done) begin
      res.group_avg_a <= div_rsp.quotient;
    end else if ((state == B_DIV_B) && div_rsp.done) begin
      res.group_avg_b <= div_rsp.quotient;
    end
  end

  assign result = res;

  // A quotient arrives only while one is awaited; unused columns read zero.
  `SKGA_ASSERT_IMP(a_done_when_waiting, clk, rst, div_rsp.done, (state == B_DIV_A) || (state == B_DIV_B))
  `SKGA_ASSERT_IMP(a_avg_b_unused_zero, clk, rst, result_valid && (cols < 2'd2), res.group_avg_b == '0)
  `SKGA_ASSERT_IMP(a_avg_a_unused_zero, clk, rst, result_valid && (cols == 2'd0), res.group_avg_a == '0)

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key group averager. A short table of
// hand-picked rows covers the field extremes, truncation toward zero, a row
// that both opens and ends a table, every column count and a change of the
// count while a group is open. About 1400 random rows follow, mostly sorted
// tables with random values, plus loose rows and tables broken off before
// their last row.
// A behavioral model in this bench predicts results the table does not type;
// all are checked in order, field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import skga_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN        = MAX_RUN_DEFAULT;
  localparam int MAX_COLS       = MAX_VALUE_COLUMNS_DEFAULT;
  // Cycles allowed for the back end to finish before a register write or the end.
  localparam int SETTLE_CYCLES  = 120;
  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 14;
  localparam int ROWS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_OFF       = 400;
  localparam int NO_WRITE       = -1;
  localparam int FROM_MODEL     = -1;

  logic        clk;
  logic        rst;
  logic        row_valid;
  logic        row_ready;
  row_item_t   row;
  logic        result_valid;
  logic        result_ready;
  group_item_t result;
  logic        cfg_we;
  logic [1:0]  cfg_data;

  // One row of the directed table, with an optional register write before it.
  typedef struct {
    bit          write_cols;
    logic [1:0]  cols;
    row_item_t   r;
    int          n;
    group_item_t e0;
    group_item_t e1;
  } dir_step_t;

  dir_step_t   dir_steps[$];
  group_item_t pending_groups[$];
  int          errors;
  int          max_gap;
  int          max_stall;
  int          hold_cycles;

  // Model state of the averager.
  logic [1:0]  cols_setting;
  bit          grp_open;
  logic [31:0] grp_key;
  int unsigned grp_rows;
  longint      grp_sum_a;
  longint      grp_sum_b;

  sorted_key_group_averager #(
    .MAX_RUN          (MAX_RUN),
    .MAX_VALUE_COLUMNS(MAX_COLS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .row_valid   (row_valid),
    .row_ready   (row_ready),
    .row         (row),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Averages of the open group under the column count now in force.
  function automatic group_item_t close_group(bit fin);
    group_item_t       g;
    int                used;
    logic signed [63:0] q;
    used = (cols_setting > 2'd2) ? 2 : int'(cols_setting);
    if (used > MAX_COLS) used = MAX_COLS;
    g = '0;
    g.group_key = grp_key;
    if (used >= 1) begin
      q = grp_sum_a / longint'(grp_rows);
      g.group_avg_a = q[31:0];
    end
    if (used >= 2) begin
      q = grp_sum_b / longint'(grp_rows);
      g.group_avg_b = q[31:0];
    end
    g.group_is_final = fin;
    return g;
  endfunction

  // Advances the model by one row and returns how many groups it closes.
  function automatic int average_row(row_item_t r, output group_item_t first,
                                     output group_item_t second);
    group_item_t res[2];
    int          n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    // A new key, or a full run, closes the open group first.
    if (grp_open && (r.row_key != grp_key || grp_rows >= MAX_RUN)) begin
      res[n] = close_group(1'b0);
      n++;
      grp_open = 1'b0;
    end
    if (!grp_open) begin
      grp_open  = 1'b1;
      grp_key   = r.row_key;
      grp_rows  = 1;
      grp_sum_a = r.row_value_a;
      grp_sum_b = r.row_value_b;
    end else begin
      grp_rows++;
      grp_sum_a += r.row_value_a;
      grp_sum_b += r.row_value_b;
    end
    // The last row of a table flushes the group and ends the table.
    if (r.row_is_final) begin
      res[n] = close_group(1'b1);
      n++;
      grp_open  = 1'b0;
      grp_key   = '0;
      grp_rows  = 0;
      grp_sum_a = 0;
      grp_sum_b = 0;
    end
    first  = res[0];
    second = res[1];
    return n;
  endfunction

  function automatic group_item_t group_of(logic [31:0] k, logic [31:0] a,
                                           logic [31:0] b, bit fin);
    group_item_t g;
    g.group_key      = k;
    g.group_avg_a    = a;
    g.group_avg_b    = b;
    g.group_is_final = fin;
    return g;
  endfunction

  function automatic void add_step(int cols, logic [31:0] k, logic [31:0] a,
                                   logic [31:0] b, bit fin, int n = FROM_MODEL,
                                   group_item_t e0 = '0, group_item_t e1 = '0);
    dir_step_t s;
    s.write_cols         = (cols >= 0);
    s.cols               = cols[1:0];
    s.r.row_key          = k;
    s.r.row_value_a      = a;
    s.r.row_value_b      = b;
    s.r.row_is_final     = fin;
    s.n                  = n;
    s.e0                 = e0;
    s.e1                 = e1;
    dir_steps.insert(dir_steps.size(), s);
  endfunction

  // Values lean toward the extremes, zero and small magnitudes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Offers one row after a random gap and records the groups it closes. Where
  // the table gives typed results, those are expected instead of the model's.
  task automatic feed(input row_item_t r, input int typed_n = FROM_MODEL,
                      input group_item_t typed_0 = '0, input group_item_t typed_1 = '0);
    group_item_t p0, p1;
    int          n;
    int          gap;
    gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    if (gap > 0) begin
      row_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_valid <= 1'b1;
    row       <= r;
    @(posedge clk);
    while (!row_ready) @(posedge clk);
    n = average_row(r, p0, p1);
    if (typed_n >= 0) begin
      if (typed_n > 0) pending_groups.insert(pending_groups.size(), typed_0);
      if (typed_n > 1) pending_groups.insert(pending_groups.size(), typed_1);
    end else begin
      if (n > 0) pending_groups.insert(pending_groups.size(), p0);
      if (n > 1) pending_groups.insert(pending_groups.size(), p1);
    end
  endtask

  // Writes the column count once the block has drained.
  task automatic set_cols(input logic [1:0] v);
    row_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cols_setting = v;
  endtask

  // Result receiver: a random stall before each item, and one long hold-off.
  initial begin : receiver
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = (max_stall > 0) ? $urandom_range(0, max_stall) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Each accepted result is compared with the oldest expected group.
  always @(posedge clk) begin : check_results
    group_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_groups.size() == 0) begin
        $error("unexpected result item: group_key %h", result.group_key);
        errors++;
      end else begin
        want = pending_groups.pop_front();
        if (result.group_key !== want.group_key) begin
          $error("group_key: expected %h, got %h", want.group_key, result.group_key);
          errors++;
        end
        if (result.group_avg_a !== want.group_avg_a) begin
          $error("group_avg_a: expected %h, got %h", want.group_avg_a, result.group_avg_a);
          errors++;
        end
        if (result.group_avg_b !== want.group_avg_b) begin
          $error("group_avg_b: expected %h, got %h", want.group_avg_b, result.group_avg_b);
          errors++;
        end
        if (result.group_is_final !== want.group_is_final) begin
          $error("group_is_final: expected %b, got %b", want.group_is_final,
                 result.group_is_final);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (row_valid && row_ready) || (result_valid && result_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    row_item_t   r;
    logic [31:0] k;
    int          sent;
    int          groups;
    int          size;
    int          kind;
    bit          closes;
    bit          one_row_groups;

    rst          <= 1'b1;
    row_valid    <= 1'b0;
    row          <= '0;
    cfg_we       <= 1'b0;
    cfg_data     <= COLS_RESET;
    errors       = 0;
    max_gap      = 15;
    max_stall    = 15;
    hold_cycles  = 0;
    cols_setting = COLS_RESET;
    grp_open     = 1'b0;
    grp_key      = '0;
    grp_rows     = 0;
    grp_sum_a    = 0;
    grp_sum_b    = 0;

    // One column after reset: extreme values, extreme keys, truncation of a
    // negative mean, and a final row that also closes the group before it.
    add_step(NO_WRITE, 32'h0001_0000, 32'h7fff_ffff, 32'h1234_5678, 1'b0, 0);
    add_step(NO_WRITE, 32'h0001_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 0);
    add_step(NO_WRITE, 32'h0002_0000, 32'h8000_0000, 32'hffff_ffff, 1'b0, 1,
             group_of(32'h0001_0000, 32'h7fff_ffff, 32'h0, 1'b0));
    add_step(NO_WRITE, 32'h0002_0000, 32'h8000_0000, 32'h0000_0000, 1'b1, 1,
             group_of(32'h0002_0000, 32'h8000_0000, 32'h0, 1'b1));
    add_step(NO_WRITE, 32'h8000_0000, 32'h0000_0003, 32'h0000_0000, 1'b0, 0);
    add_step(NO_WRITE, 32'h8000_0000, 32'hffff_fffc, 32'h0000_0000, 1'b0, 0);
    add_step(NO_WRITE, 32'h8000_0000, 32'hffff_fffc, 32'h0000_0000, 1'b0, 0);
    add_step(NO_WRITE, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0000, 1'b1, 2,
             group_of(32'h8000_0000, 32'hffff_ffff, 32'h0, 1'b0),
             group_of(32'h7fff_ffff, 32'h0000_0005, 32'h0, 1'b1));
    // A table of one row.
    add_step(NO_WRITE, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 1'b1, 1,
             group_of(32'h0, 32'h0000_0001, 32'h0, 1'b1));
    // The count goes to two while this group is open.
    add_step(NO_WRITE, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 0);
    add_step(2, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1,
             group_of(32'hffff_ffff, 32'h7fff_ffff, 32'h0, 1'b1));
    add_step(NO_WRITE, 32'h0000_0005, 32'hffff_fff9, 32'h0000_0007, 1'b0);
    add_step(NO_WRITE, 32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_step(NO_WRITE, 32'h0000_0006, 32'h0000_0001, 32'hffff_ffff, 1'b1, 2,
             group_of(32'h0000_0005, 32'hffff_fffd, 32'h0000_0003, 1'b0),
             group_of(32'h0000_0006, 32'h0000_0001, 32'hffff_ffff, 1'b1));
    // No value columns: keys only.
    add_step(0, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_step(NO_WRITE, 32'h0000_0001, 32'h0001_2345, 32'h0000_6789, 1'b0);
    add_step(NO_WRITE, 32'h0000_0002, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1,
             group_of(32'h0000_0001, 32'h0, 32'h0, 1'b0));
    add_step(NO_WRITE, 32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 1'b1, 1,
             group_of(32'h0000_0002, 32'h0, 32'h0, 1'b1));
    // A count of three behaves as two.
    add_step(3, 32'h1234_5678, 32'h0000_000a, 32'hffff_fff6, 1'b0);
    add_step(NO_WRITE, 32'h1234_5678, 32'h0000_000b, 32'hffff_fff5, 1'b1, 1,
             group_of(32'h1234_5678, 32'h0000_000a, 32'hffff_fff6, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].write_cols) set_cols(dir_steps[i].cols);
      feed(dir_steps[i].r, dir_steps[i].n, dir_steps[i].e0, dir_steps[i].e1);
    end

    // Random phases, each with its own column count and stall pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_cols(2'(ph < 4 ? ph : $urandom_range(0, 3)));
      case ($urandom_range(0, 3))
        0: begin
          max_gap   = 15;
          max_stall = 15;
        end
        1: begin
          max_gap   = 0;
          max_stall = 0;
        end
        2: begin
          max_gap   = 0;
          max_stall = 15;
        end
        default: begin
          max_gap   = 15;
          max_stall = 0;
        end
      endcase
      // One phase of single-row groups at full rate against a receiver that
      // holds off, so that the group queue fills and rows back up.
      one_row_groups = (ph == PRESSURE_PHASE);
      if (one_row_groups) begin
        max_gap     = 0;
        hold_cycles = HOLD_OFF;
      end
      sent = 0;
      while (sent < ROWS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind == 0 && !one_row_groups) begin
          // A loose row with any key and a random final flag.
          r.row_key      = $urandom;
          r.row_value_a  = pick_value();
          r.row_value_b  = pick_value();
          r.row_is_final = ($urandom_range(0, 3) == 0);
          feed(r);
          sent++;
        end else begin
          // A sorted table; some are broken off without their final row.
          closes = (kind != 1);
          groups = $urandom_range(1, 8);
          k      = $urandom;
          for (int g = 0; g < groups; g++) begin
            if (one_row_groups)
              size = 1;
            else if ($urandom_range(0, 7) == 0)
              size = $urandom_range(8, 40);
            else
              size = $urandom_range(1, 4);
            for (int j = 0; j < size; j++) begin
              r.row_key      = k;
              r.row_value_a  = pick_value();
              r.row_value_b  = pick_value();
              r.row_is_final = closes && (g == groups - 1) && (j == size - 1);
              feed(r);
              sent++;
            end
            k = k + $urandom_range(1, 32'h0010_0000);
          end
        end
      end
    end

    row_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
